FILE: sv/mtr_pkg.sv
// Shared constants for the MT19937 generator core.
// No dependencies; imported by the core and the remainder unit.
`timescale 1ns / 1ps
package mtr_pkg;
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int WORD_W       = 32;

    localparam logic [ADDR_W-1:0] LAST_IDX     = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] POS_SEEDED   = ADDR_W'(STATE_WORDS);
    localparam logic [ADDR_W-1:0] POS_UNSEEDED = ADDR_W'(STATE_WORDS + 1);

    localparam logic [12:0]       SEED_MULT    = 13'd6069;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
    localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;

    localparam logic [1:0] OP_SEED    = 2'd0;
    localparam logic [1:0] OP_RAW     = 2'd1;
    localparam logic [1:0] OP_UNIFORM = 2'd2;

    // remainder unit result
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } mtr_mod_res_t;
endpackage

FILE: sv/mersenne_twister_rng_core.sv
// MT19937 generator core: state memory, seed and twist sequencer, tempering.
// Depends on mtr_pkg, mtr_ram and mtr_mod.
//
//  channel | dir | width | contents
//  s_*     | in  | 72    | opcode [1:0], seed_value [33:2], bound [65:34]
//  m_*     | out | 40    | value [31:0], error [32]
//
// Seed: writes all 624 state words, one word a cycle, then the hand-off (the twist within a draw).
// Twist: a neighbour read and a far read for every word.
// Raw draw: ST_DRAW, ST_RD, ST_TEMP and ST_RESP from accept to result, plus a twist when
// the state is used up, plus a seed with 4357 on the first draw after reset. Uniform draw:
// each attempt adds ST_DIV, waiting on the one-bit-a-cycle remainder unit.
// Input is taken only when the sequencer is idle; a held result stalls it at the hand-off.
`timescale 1ns / 1ps
module mersenne_twister_rng_core
    import mtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // opcode, seed_value, bound
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // value, error
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SEED  = 4'd1;
    localparam logic [3:0] ST_DRAW  = 4'd2;
    localparam logic [3:0] ST_PRIME = 4'd3;
    localparam logic [3:0] ST_TW_A  = 4'd4;
    localparam logic [3:0] ST_TW_B  = 4'd5;
    localparam logic [3:0] ST_TW_C  = 4'd6;
    localparam logic [3:0] ST_RD    = 4'd7;
    localparam logic [3:0] ST_TEMP  = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_RESP  = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [1:0]        op_reg, op_next;
    logic [WORD_W-1:0] bound_reg, bound_next;
    logic [WORD_W-1:0] run_reg, run_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic [WORD_W-1:0] nxt_reg, nxt_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              err_reg, err_next;
    logic              ovalid_reg, ovalid_next;
    logic [WORD_W-1:0] oval_reg, oval_next;
    logic              oerr_reg, oerr_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;
    logic              div_start;
    mtr_mod_res_t      div_res;

    logic [1:0]        in_op;
    logic [WORD_W-1:0] in_seed, in_bound;
    logic [ADDR_W:0]   idx2_sum, far_sum;
    logic [ADDR_W-1:0] idx2, far_idx;
    logic [WORD_W-1:0] y_tw, tw_word, tmp_a, tmp_b, tmp_c, tempered;
    logic [44:0]       run_prod;

    assign in_op    = s_tdata[1:0];
    assign in_seed  = s_tdata[33:2];
    assign in_bound = s_tdata[65:34];

    mtr_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // the tempered word enters the remainder unit in the cycle it is formed
    mtr_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_next),
        .divisor  (bound_reg),
        .res      (div_res)
    );

    // wrapped indices k+2 and k+397
    assign idx2_sum = {1'b0, k_reg} + (ADDR_W+1)'(2);
    assign idx2     = (idx2_sum >= (ADDR_W+1)'(STATE_WORDS))
                      ? ADDR_W'(idx2_sum - (ADDR_W+1)'(STATE_WORDS)) : idx2_sum[ADDR_W-1:0];
    assign far_sum  = {1'b0, k_reg} + (ADDR_W+1)'(TWIST_OFFSET);
    assign far_idx  = (far_sum >= (ADDR_W+1)'(STATE_WORDS))
                      ? ADDR_W'(far_sum - (ADDR_W+1)'(STATE_WORDS)) : far_sum[ADDR_W-1:0];

    assign y_tw    = (cur_reg & HIGH_BIT) | (nxt_reg & LOW_BITS);
    assign tw_word = rd_data ^ (y_tw >> 1) ^ (y_tw[0] ? MATRIX_A : '0);

    assign tmp_a    = rd_data ^ (rd_data >> 11);
    assign tmp_b    = tmp_a ^ ((tmp_a << 7) & TEMPER_B);
    assign tmp_c    = tmp_b ^ ((tmp_b << 15) & TEMPER_C);
    assign tempered = tmp_c ^ (tmp_c >> 18);

    assign run_prod = run_reg * SEED_MULT;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        op_next     = op_reg;
        bound_next  = bound_reg;
        run_next    = run_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        x_next      = x_reg;
        res_next    = res_reg;
        err_next    = err_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        oerr_next   = oerr_reg;
        wr_en       = 1'b0;
        wr_addr     = k_reg;
        wr_data     = run_reg;
        rd_addr     = k_reg;
        div_start   = 1'b0;

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = in_op;
                    bound_next = in_bound;
                    res_next   = '0;
                    err_next   = 1'b0;
                    k_next     = '0;
                    case (in_op)
                        OP_SEED:
                        begin
                            run_next   = in_seed;
                            state_next = ST_SEED;
                        end
                        OP_RAW:
                            state_next = ST_DRAW;
                        OP_UNIFORM:
                        begin
                            if (in_bound == '0)
                            begin
                                err_next   = 1'b1;
                                state_next = ST_RESP;
                            end
                            else
                                state_next = ST_DRAW;
                        end
                        default:
                            state_next = ST_RESP;
                    endcase
                end
            end
            ST_SEED:
            begin
                wr_en    = 1'b1;
                run_next = run_prod[WORD_W-1:0];
                k_next   = k_reg + ADDR_W'(1);
                if (k_reg == LAST_IDX)
                begin
                    pos_next   = POS_SEEDED;
                    k_next     = '0;
                    state_next = (op_reg == OP_SEED) ? ST_RESP : ST_PRIME;
                end
            end
            ST_DRAW:
            begin
                k_next = '0;
                if (pos_reg >= POS_UNSEEDED)
                begin
                    run_next   = DEFAULT_SEED;
                    state_next = ST_SEED;
                end
                else if (pos_reg == POS_SEEDED)
                    state_next = ST_PRIME;
                else
                    state_next = ST_RD;
            end
            ST_PRIME:
            begin
                rd_addr    = '0;
                state_next = ST_TW_A;
            end
            ST_TW_A:
            begin
                cur_next   = rd_data;
                rd_addr    = k_reg + ADDR_W'(1);
                state_next = ST_TW_B;
            end
            ST_TW_B:
            begin
                nxt_next   = rd_data;
                rd_addr    = far_idx;
                state_next = ST_TW_C;
            end
            ST_TW_C:
            begin
                wr_en    = 1'b1;
                wr_data  = tw_word;
                cur_next = nxt_reg;
                rd_addr  = idx2;
                if (k_reg == LAST_IDX)
                begin
                    pos_next   = '0;
                    state_next = ST_RD;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = ST_TW_B;
                end
            end
            ST_RD:
            begin
                rd_addr    = pos_reg;
                pos_next   = pos_reg + ADDR_W'(1);
                state_next = ST_TEMP;
            end
            ST_TEMP:
            begin
                x_next = tempered;
                if (op_reg == OP_UNIFORM)
                    state_next = ST_DIV;
                else
                begin
                    res_next   = tempered;
                    state_next = ST_RESP;
                end
                div_start = (op_reg == OP_UNIFORM);
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    // reject draws that fall in the short last bucket
                    if ((x_reg - div_res.rem) > (WORD_W'(0) - bound_reg))
                        state_next = ST_DRAW;
                    else
                    begin
                        res_next   = div_res.rem;
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    oval_next   = res_reg;
                    oerr_next   = err_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= POS_UNSEEDED;
            k_reg      <= '0;
            op_reg     <= OP_SEED;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            k_reg      <= k_next;
            op_reg     <= op_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        run_reg   <= run_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        x_reg     <= x_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
        oval_reg  <= oval_next;
        oerr_reg  <= oerr_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, oerr_reg, oval_reg};

    a_wr_only_seed_twist: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SEED || state_reg == ST_TW_C))
        else $error("state memory written outside seed or twist");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_UNSEEDED)
        else $error("word position out of range");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == ST_DIV)
        else $error("remainder finished outside a uniform draw");
    a_twist_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_C && k_reg == LAST_IDX) |=> pos_reg == '0)
        else $error("twist end did not rewind the position");
endmodule

FILE: sv/mtr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: sv/mtr_mod.sv
// Iterative 32-bit remainder unit, one quotient bit per cycle.
// Depends on mtr_pkg.
`timescale 1ns / 1ps
module mtr_mod
    import mtr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output mtr_mod_res_t      res
);
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   shifted;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            // subtract where the partial remainder reaches the divisor
            if (shifted >= {1'b0, dvs_reg})
                rem_next = WORD_W'(shifted - {1'b0, dvs_reg});
            else
                rem_next = shifted[WORD_W-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("remainder done without a running division");
endmodule
